[rtl/core/gear_position_settle_qualifier_core_assert.svh]
// Assertion macros shared by the qualifier core.
`ifndef GEAR_POSITION_SETTLE_QUALIFIER_CORE_ASSERT_SVH
`define GEAR_POSITION_SETTLE_QUALIFIER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GPSQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define GPSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/gpsq_pkg.sv]
`timescale 1ns / 1ps
package gpsq_pkg;

  localparam logic [1:0] REQ_STEP       = 2'd0;
  localparam logic [1:0] REQ_INIT       = 2'd1;
  localparam logic [1:0] REQ_READ_CLEAR = 2'd2;

  localparam logic [1:0] PH_POLLING = 2'd0;
  localparam logic [1:0] PH_ARMED   = 2'd1;
  localparam logic [1:0] PH_MOVING  = 2'd2;
  localparam logic [1:0] PH_UPDATE  = 2'd3;

  localparam logic [2:0] GEAR_NEUTRAL  = 3'd7;
  localparam logic [3:0] TOP_GEAR_CODE = 4'd6;

  localparam int unsigned SETTLE_BITS = 32;
  localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = 32'd50;

  typedef struct packed {
    logic       flag_out;
    logic [2:0] active_gear;
  } result_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       pending_flag;
  } status_t;

  // Reverse and gears 1-6 pass through; any other code is neutral.
  function automatic logic [2:0] decode_position(input logic [3:0] code);
    logic [2:0] gear;
    gear = (code <= TOP_GEAR_CODE) ? code[2:0] : GEAR_NEUTRAL;
    return gear;
  endfunction

endpackage

[rtl/core/gear_position_settle_qualifier_core.sv]
`timescale 1ns / 1ps
// Gear position settle qualifier. Each input beat carries a request kind in
// s_tuser (step with sample, init active mode, read and clear the update flag)
// and produces exactly one result beat: the committed gear after the request
// (0 reverse, 1-6 gears, 7 neutral) and, on a read request, the update flag as
// it stood before clearing. A step arms on a changed position, waits until
// more than settle_time ticks have passed (wrap-around difference of
// now_time), rechecks, and commits on the following step; a moving vehicle
// forces neutral at once. Rate: one beat per clock, sustained while m_tready
// stays high; a beat passes from the input register through one pass of the
// step logic into the result register, and the two registers together let a
// new beat in while a result waits on m_tready. The user must write
// settle_time through cfg_* while the block is idle (the block has no check for it); reset value 50.
`include "gear_position_settle_qualifier_core_assert.svh"
module gear_position_settle_qualifier_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input beat.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [3:0] position_code, [4] is_moving, [TIME_BITS+4:5] now_time, zero pad
  input  logic [((TIME_BITS+5+7)/8)*8-1:0]    s_tdata,
  // [1:0] req_type
  input  logic [1:0]                          s_tuser,
  // Result beat.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] active_gear, [3] flag_out, [7:4] zero
  output logic [7:0]                          m_tdata,
  // settle_time write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gpsq_pkg::SETTLE_BITS-1:0]    cfg_data
);

  logic                 in_valid;
  logic [1:0]           in_req;
  logic [3:0]           in_code;
  logic                 in_moving;
  logic [TIME_BITS-1:0] in_now;
  logic                 advance;
  gpsq_pkg::result_t    result;
  gpsq_pkg::status_t    status;

  // Move the held beat forward whenever the result register is free or drains.
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign cfg_ready = 1'b1;

  gpsq_in_stage #(
    .TIME_BITS (TIME_BITS)
  ) u_in (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_tvalid),
    .s_ready  (s_tready),
    .s_req    (s_tuser),
    .s_code   (s_tdata[3:0]),
    .s_moving (s_tdata[4]),
    .s_now    (s_tdata[TIME_BITS+4:5]),
    .advance  (advance),
    .valid    (in_valid),
    .req      (in_req),
    .code     (in_code),
    .moving   (in_moving),
    .now      (in_now)
  );

  // Step logic and qualifier state; state advances only with a beat.
  gpsq_qualify #(
    .TIME_BITS (TIME_BITS)
  ) u_qualify (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .advance  (advance),
    .req      (in_req),
    .code     (in_code),
    .moving   (in_moving),
    .now      (in_now),
    .result   (result),
    .status   (status)
  );

  gpsq_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // The moving phase is resolved within its own step and never stored.
  `GPSQ_ASSERT_NOW(a_no_stored_moving, 1'b1, status.phase != gpsq_pkg::PH_MOVING, "moving phase stored")
  // A reported flag must be cleared by the same beat.
  `GPSQ_ASSERT_NEXT(a_flag_cleared, advance && result.flag_out, !status.pending_flag, "flag not cleared")
  // An empty result register never stalls the input side.
  `GPSQ_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")
  // Both registers full and output stalled: input must back-pressure.
  `GPSQ_ASSERT_NOW(a_backpressure, in_valid && m_tvalid && !m_tready, !s_tready, "overrun")

endmodule

[rtl/core/gpsq_in_stage.sv]
`timescale 1ns / 1ps
module gpsq_in_stage #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  logic [1:0]           s_req,
  input  logic [3:0]           s_code,
  input  logic                 s_moving,
  input  logic [TIME_BITS-1:0] s_now,
  input  logic                 advance,
  output logic                 valid,
  output logic [1:0]           req,
  output logic [3:0]           code,
  output logic                 moving,
  output logic [TIME_BITS-1:0] now
);

  logic accept;

  // Take a new beat when empty or when the held one moves on this cycle.
  assign s_ready = !valid || advance;
  assign accept  = s_valid && s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept || (valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req    <= s_req;
      code   <= s_code;
      moving <= s_moving;
      now    <= s_now;
    end
  end

endmodule

[rtl/core/gpsq_qualify.sv]
`timescale 1ns / 1ps
module gpsq_qualify #(
  parameter int TIME_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gpsq_pkg::SETTLE_BITS-1:0]   cfg_data,
  input  logic                               advance,
  input  logic [1:0]                         req,
  input  logic [3:0]                         code,
  input  logic                               moving,
  input  logic [TIME_BITS-1:0]               now,
  output gpsq_pkg::result_t                  result,
  output gpsq_pkg::status_t                  status
);

  localparam int CMP_BITS =
    (TIME_BITS > gpsq_pkg::SETTLE_BITS) ? TIME_BITS : gpsq_pkg::SETTLE_BITS;

  logic [gpsq_pkg::SETTLE_BITS-1:0] settle_time;
  logic [1:0]           phase, phase_next, phase_eff;
  logic [2:0]           committed_mode, committed_mode_next;
  logic [2:0]           candidate_mode, candidate_mode_next;
  logic [TIME_BITS-1:0] arm_stamp, arm_stamp_next;
  logic                 pending_flag, pending_flag_next;
  logic                 flag_report;
  logic [2:0]           sampled;
  logic [TIME_BITS-1:0] elapsed;
  logic                 settled;

  assign sampled = gpsq_pkg::decode_position(code);
  // Wrap-around difference, then strict compare against the settle time.
  assign elapsed = now - arm_stamp;
  assign settled = CMP_BITS'(elapsed) > CMP_BITS'(settle_time);

  always_comb begin
    phase_next          = phase;
    committed_mode_next = committed_mode;
    candidate_mode_next = candidate_mode;
    arm_stamp_next      = arm_stamp;
    pending_flag_next   = pending_flag;
    flag_report         = 1'b0;
    phase_eff           = moving ? gpsq_pkg::PH_MOVING : phase;
    unique case (req)
      gpsq_pkg::REQ_STEP: begin
        unique case (phase_eff)
          gpsq_pkg::PH_POLLING: begin
            if (sampled != committed_mode) begin
              phase_next          = gpsq_pkg::PH_ARMED;
              candidate_mode_next = sampled;
              arm_stamp_next      = now;
            end
          end
          gpsq_pkg::PH_MOVING: begin
            committed_mode_next = gpsq_pkg::GEAR_NEUTRAL;
            phase_next          = gpsq_pkg::PH_POLLING;
          end
          gpsq_pkg::PH_ARMED: begin
            if (settled) begin
              phase_next = (sampled == candidate_mode) ? gpsq_pkg::PH_UPDATE
                                                       : gpsq_pkg::PH_POLLING;
            end
          end
          gpsq_pkg::PH_UPDATE: begin
            committed_mode_next = candidate_mode;
            if (candidate_mode != gpsq_pkg::GEAR_NEUTRAL) begin
              pending_flag_next = 1'b1;
            end
            phase_next = gpsq_pkg::PH_POLLING;
          end
          default: begin
            phase_next = gpsq_pkg::PH_POLLING;
          end
        endcase
      end
      gpsq_pkg::REQ_INIT: begin
        committed_mode_next = sampled;
      end
      gpsq_pkg::REQ_READ_CLEAR: begin
        flag_report       = pending_flag;
        pending_flag_next = 1'b0;
      end
      default: begin
        flag_report = 1'b0;
      end
    endcase
  end

  assign result.active_gear = committed_mode_next;
  assign result.flag_out    = flag_report;
  assign status.phase        = phase;
  assign status.pending_flag = pending_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_time <= gpsq_pkg::SETTLE_RESET;
    end else if (cfg_we) begin
      settle_time <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= gpsq_pkg::PH_POLLING;
      committed_mode <= gpsq_pkg::GEAR_NEUTRAL;
      candidate_mode <= gpsq_pkg::GEAR_NEUTRAL;
      arm_stamp      <= '0;
      pending_flag   <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      committed_mode <= committed_mode_next;
      candidate_mode <= candidate_mode_next;
      arm_stamp      <= arm_stamp_next;
      pending_flag   <= pending_flag_next;
    end
  end

endmodule

[rtl/core/gpsq_out_stage.sv]
`timescale 1ns / 1ps
module gpsq_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  gpsq_pkg::result_t result,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata
);

  gpsq_pkg::result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {4'b0000, held.flag_out, held.active_gear};

endmodule
